FILE: hw/rtl/datagram_admission_queue_defines.svh
// assertion macros for the datagram admission queue
// no dependencies; included by files that carry concurrent assertions
`ifndef DATAGRAM_ADMISSION_QUEUE_DEFINES_SVH
`define DATAGRAM_ADMISSION_QUEUE_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define DADQ_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define DADQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/dadq_pkg.sv
// shared types and constants for the datagram admission queue
// no dependencies; imported by the csr, core and top-level modules of the block
`default_nettype none

package dadq_pkg;

   localparam int LEN_W      = 16;
   localparam int BYTES_W    = 20;
   localparam int ID_W       = 32;
   localparam int CID_W      = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_PAD_W  = 3;
   localparam int RSP_DATA_W = 152;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_LINK   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KNOWN  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PEER   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PATH   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CID    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_BUDGET = 3'd5;

   localparam logic [LEN_W-1:0]   PATH_RESET   = 16'd1200;
   localparam logic [BYTES_W-1:0] BUDGET_RESET = 20'h10000;

   // aead tag bytes appended to each packet
   localparam int TAG_BYTES = 16;
   // short header flags, packet number, frame type, length field and aead tag
   localparam int FIXED_OVERHEAD = 1 + 4 + 1 + 2 + TAG_BYTES;
   // frame type and length bytes inside the peer's frame limit
   localparam int PEER_OVERHEAD = 3;

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_POP   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_UNAVAIL  = 3'd1,
      ST_TOO_LONG = 3'd2,
      ST_OVER     = 3'd3,
      ST_FULL     = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTES_W-1:0] budget;
      logic [LEN_W-1:0]   max_payload;
   } cfg_type;

   typedef struct packed {
      op_type             opcode;
      logic [LEN_W-1:0]   payload_length;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] len;
   } front_type;

   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    assigned_id;
      logic               front_valid;
      logic [BYTES_W-1:0] queued_bytes;
      logic [ID_W-1:0]    dropped_count;
      logic [LEN_W-1:0]   max_payload;
   } res_type;

endpackage

`default_nettype wire

FILE: hw/rtl/dadq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; read during write to the same address returns old data
`default_nettype none

module dadq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hw/rtl/dadq_csr.sv
// configuration registers and registered payload limit
// depends on dadq_pkg
`default_nettype none

module dadq_csr import dadq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic                 link_ff;
   logic                 known_ff;
   logic [LEN_W-1:0]     peer_ff;
   logic [LEN_W-1:0]     path_ff;
   logic [CID_W-1:0]     cid_ff;
   logic [BYTES_W-1:0]   budget_ff;
   logic [LEN_W-1:0]     limit_ff;
   logic [LEN_W-1:0]     limit_in;
   logic [LEN_W-1:0]     overhead;
   logic [LEN_W-1:0]     room;
   logic [LEN_W-1:0]     peer_room;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_stb;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_stb  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff   <= 1'b0;
         known_ff  <= 1'b0;
         peer_ff   <= '0;
         path_ff   <= PATH_RESET;
         cid_ff    <= '0;
         budget_ff <= BUDGET_RESET;
         limit_ff  <= '0;
      end else begin
         limit_ff <= limit_in;
         if (wr_stb) begin
            case (reg_idx)
               REG_LINK:   link_ff   <= pwdata[0];
               REG_KNOWN:  known_ff  <= pwdata[0];
               REG_PEER:   peer_ff   <= pwdata[LEN_W-1:0];
               REG_PATH:   path_ff   <= pwdata[LEN_W-1:0];
               REG_CID:    cid_ff    <= pwdata[CID_W-1:0];
               REG_BUDGET: budget_ff <= pwdata[BYTES_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // both headroom terms saturate at zero
   always_comb begin
      overhead  = LEN_W'(FIXED_OVERHEAD) + LEN_W'(cid_ff);
      room      = (path_ff > overhead) ? (path_ff - overhead) : '0;
      peer_room = (peer_ff > LEN_W'(PEER_OVERHEAD)) ? (peer_ff - LEN_W'(PEER_OVERHEAD)) : '0;
      if (!link_ff || !known_ff || peer_ff == '0) begin
         limit_in = '0;
      end else begin
         limit_in = (peer_room < room) ? peer_room : room;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LINK:   prdata = CSR_DATA_W'(link_ff);
         REG_KNOWN:  prdata = CSR_DATA_W'(known_ff);
         REG_PEER:   prdata = CSR_DATA_W'(peer_ff);
         REG_PATH:   prdata = CSR_DATA_W'(path_ff);
         REG_CID:    prdata = CSR_DATA_W'(cid_ff);
         REG_BUDGET: prdata = CSR_DATA_W'(budget_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg.budget      = budget_ff;
   assign cfg.max_payload = limit_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dadq_core.sv
// queue state, admission checks and descriptor storage
// depends on dadq_pkg and dadq_ram
`default_nettype none

module dadq_core import dadq_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          op_valid,
   input  wire req_type       op,
   output res_type            result,
   output front_type          front,
   output logic      [CW-1:0] q_count,
   output logic      [AW-1:0] q_head
);

   localparam int SW = AW + 1;
   localparam int EW = $bits(front_type);

   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [ID_W-1:0]    drop_ff, drop_in;
   logic               byp_ff, byp_in;
   logic [EW-1:0]      byp_data_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic [EW-1:0]      rd_data;
   logic [SW-1:0]      tail_sum;
   logic [SW-1:0]      tail_wrap;
   logic [SW-1:0]      head_sum;
   logic [SW-1:0]      head_wrap;
   logic [BYTES_W:0]   bytes_sum;
   status_type         status;
   logic [ID_W-1:0]    assigned;

   dadq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   // an entry written at the slot being read is not yet in the ram read data, so it is bypassed
   assign front   = byp_ff ? front_type'(byp_data_ff) : front_type'(rd_data);
   assign wr_data = {next_id_ff, op.payload_length};

   always_comb begin
      tail_sum  = SW'(head_ff) + SW'(count_ff);
      tail_wrap = (tail_sum >= SW'(DEPTH)) ? (tail_sum - SW'(DEPTH)) : tail_sum;
      head_sum  = SW'(head_ff) + SW'(1);
      head_wrap = (head_sum >= SW'(DEPTH)) ? (head_sum - SW'(DEPTH)) : head_sum;
      bytes_sum = {1'b0, bytes_ff} + (BYTES_W+1)'(op.payload_length);
      wr_addr   = tail_wrap[AW-1:0];

      head_in    = head_ff;
      count_in   = count_ff;
      bytes_in   = bytes_ff;
      next_id_in = next_id_ff;
      drop_in    = drop_ff;
      wr_en      = 1'b0;
      status     = ST_OK;
      assigned   = '0;

      if (op_valid) begin
         case (op.opcode)
            OP_SEND: begin
               if (cfg.max_payload == '0) begin
                  status = ST_UNAVAIL;
               end else if (op.payload_length > cfg.max_payload) begin
                  status = ST_TOO_LONG;
               end else if (bytes_sum > {1'b0, cfg.budget}) begin
                  status  = ST_OVER;
                  drop_in = drop_ff + ID_W'(1);
               end else if (count_ff >= CW'(DEPTH)) begin
                  status = ST_FULL;
               end else begin
                  wr_en      = 1'b1;
                  assigned   = next_id_ff;
                  next_id_in = next_id_ff + ID_W'(1);
                  count_in   = count_ff + CW'(1);
                  bytes_in   = bytes_sum[BYTES_W-1:0];
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  status = ST_EMPTY;
               end else begin
                  bytes_in = bytes_ff - BYTES_W'(front.len);
                  count_in = count_ff - CW'(1);
                  // queue drains back to slot zero
                  head_in  = (count_ff == CW'(1)) ? '0 : head_wrap[AW-1:0];
               end
            end
            OP_FLUSH: begin
               drop_in  = drop_ff + ID_W'(count_ff);
               count_in = '0;
               head_in  = '0;
               bytes_in = '0;
            end
            default: begin
            end
         endcase
      end

      byp_in = wr_en && (wr_addr == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         bytes_ff   <= '0;
         next_id_ff <= '0;
         drop_ff    <= '0;
         byp_ff     <= 1'b0;
      end else begin
         head_ff    <= head_in;
         count_ff   <= count_in;
         bytes_ff   <= bytes_in;
         next_id_ff <= next_id_in;
         drop_ff    <= drop_in;
         byp_ff     <= byp_in;
      end
      byp_data_ff <= wr_data;
   end

   assign result.status        = status;
   assign result.assigned_id   = assigned;
   assign result.front_valid   = (count_in != '0);
   assign result.queued_bytes  = bytes_in;
   assign result.dropped_count = drop_in;
   assign result.max_payload   = cfg.max_payload;

   assign q_count = count_ff;
   assign q_head  = head_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/datagram_admission_queue.sv
// top level of the datagram admission queue: request and result registers
// depends on dadq_pkg, dadq_csr, dadq_core and the assertion macro header
//
//   port group   role                         payload
//   req_*        request stream in            tuser opcode, tdata payload length
//   rsp_*        result stream out            tuser status, tdata result fields
//   csr_*        apb register port            six configuration registers
//
// one request per cycle while the result stream is not stalled
// a request sits in the input register, is checked and applied against the queue
// state in one pass, and its result is held in the output register until taken
// a stalled result holds the pass; the input register still takes one request
// reset is synchronous; no clearing pass, the descriptor ram is read only at live slots
`default_nettype none
`include "datagram_admission_queue_defines.svh"

module datagram_admission_queue import dadq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] payload_length
   input  wire logic [1:0]            req_tuser,  // [1:0] opcode
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] assigned_id, [32] front_valid, [48:33] front_length,
   // [80:49] front_id, [100:81] queued_bytes, [132:101] dropped_count,
   // [148:133] max_payload, [151:149] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic      [2:0]            rsp_tuser,  // [2:0] status
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cfg_type          cfg;
   req_type          in_ff;
   logic             in_valid_ff, in_valid_in;
   res_type          out_ff;
   res_type          res;
   logic             out_valid_ff, out_valid_in;
   logic             advance;
   front_type        front;
   logic [LEN_W-1:0] front_len;
   logic [ID_W-1:0]  front_id;
   logic [CW-1:0]    q_count;
   logic [AW-1:0]    q_head;

   dadq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dadq_core #(
      .DEPTH (QUEUE_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .op_valid (advance),
      .op       (in_ff),
      .result   (res),
      .front    (front),
      .q_count  (q_count),
      .q_head   (q_head)
   );

   // the pass runs when the held request has a free result slot behind it
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_ff.opcode         <= op_type'(req_tuser);
         in_ff.payload_length <= req_tdata;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   // front entry comes straight off the ram, which only moves with the next pass
   assign front_len = out_ff.front_valid ? front.len : '0;
   assign front_id  = out_ff.front_valid ? front.id  : '0;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.max_payload, out_ff.dropped_count,
                        out_ff.queued_bytes, front_id, front_len, out_ff.front_valid,
                        out_ff.assigned_id};

   `DADQ_ASSERT_ALWAYS(a_count_bound, clock, reset, q_count <= CW'(QUEUE_DEPTH), "entry count above depth")
   `DADQ_ASSERT_IMPLY(a_empty_head, clock, reset, q_count == '0, q_head == '0, "empty queue with head off zero")
   `DADQ_ASSERT_IMPLY(a_front_flag, clock, reset, out_valid_ff, out_ff.front_valid == (q_count != '0), "held front flag disagrees with queue state")

endmodule

`default_nettype wire

FILE: verif/datagram_admission_queue_tb.sv
// self-checking bench for the datagram admission queue: streams send, pop, flush and
// no-op requests under several register settings and checks every result field
// against a predictor kept in this file; depends on dadq_pkg and the rtl top level
`timescale 1ns / 100ps

module datagram_admission_queue_tb;
   import dadq_pkg::*;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = 4;
   localparam int AEAD_TAG    = 16;
   localparam int HDR_BYTES   = 1 + 4 + 1 + 2;
   localparam int PHASES      = 12;
   localparam int PHASE_W     = 4;
   localparam int PHASE_ITEMS = 117;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      op_type      op;
      logic [15:0] length;
   } request_type;

   typedef struct {
      status_type  status;
      logic [31:0] assigned_id;
      logic        front_valid;
      logic [15:0] front_length;
      logic [31:0] front_id;
      logic [19:0] queued_bytes;
      logic [31:0] dropped_count;
      logic [15:0] max_payload;
   } reply_type;

   typedef struct {
      logic        link;
      logic        known;
      logic [15:0] peer;
      logic [15:0] path;
      logic [4:0]  cid;
      logic [19:0] budget;
   } link_cfg_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [15:0] payload_length
   logic [1:0]            req_tuser;   // [1:0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [31:0] assigned_id, [32] front_valid, [48:33] front_length, [80:49] front_id,
   // [100:81] queued_bytes, [132:101] dropped_count, [148:133] max_payload
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;   // [2:0] status
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   datagram_admission_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow registers
   logic        cfg_link;
   logic        cfg_known;
   logic [15:0] cfg_peer;
   logic [15:0] cfg_path;
   logic [4:0]  cfg_cid;
   logic [19:0] cfg_budget;

   // predicted queue state
   logic [15:0] len_slots [SLOTS];
   logic [31:0] id_slots [SLOTS];
   int unsigned head_slot;
   int unsigned entry_total;
   int unsigned bytes_waiting;
   logic [31:0] next_datagram_id;
   logic [31:0] drops_seen;

   request_type  outbound_requests [$];
   reply_type    predicted_replies [$];
   link_cfg_type phase_cfg [PHASES];
   request_type  item;
   reply_type    want;

   int          issued_total;
   int          accepted_total;
   int          fail_count;
   int          idle_mode;
   logic        hold_request;
   logic        rx_hold;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int unsigned payload_cap();
      int unsigned overhead;
      int unsigned room;
      int unsigned peer_room;
      if (!cfg_link || !cfg_known || cfg_peer == 0)
         return 0;
      overhead  = HDR_BYTES + AEAD_TAG + cfg_cid;
      room      = (cfg_path > overhead) ? cfg_path - overhead : 0;
      peer_room = (cfg_peer > 3) ? cfg_peer - 3 : 0;
      return (peer_room < room) ? peer_room : room;
   endfunction

   task automatic apply_request(input op_type op, input logic [15:0] len);
      reply_type   r;
      int unsigned cap;
      int unsigned slot;
      cap = payload_cap();
      r.status      = ST_OK;
      r.assigned_id = '0;
      case (op)
         OP_SEND: begin
            if (cap == 0)
               r.status = ST_UNAVAIL;
            else if (len > cap)
               r.status = ST_TOO_LONG;
            else if (bytes_waiting + len > cfg_budget) begin
               drops_seen = drops_seen + 1;
               r.status   = ST_OVER;
            end else if (entry_total >= SLOTS)
               r.status = ST_FULL;
            else begin
               slot                         = (head_slot + entry_total) % SLOTS;
               len_slots[slot[SLOT_W-1:0]]  = len;
               id_slots[slot[SLOT_W-1:0]]   = next_datagram_id;
               r.assigned_id                = next_datagram_id;
               next_datagram_id             = next_datagram_id + 1;
               entry_total++;
               bytes_waiting = (bytes_waiting + len) & 20'hFFFFF;
            end
         end
         OP_POP: begin
            if (entry_total == 0)
               r.status = ST_EMPTY;
            else begin
               bytes_waiting = (bytes_waiting - len_slots[head_slot[SLOT_W-1:0]]) &
                               20'hFFFFF;
               head_slot     = (head_slot + 1) % SLOTS;
               entry_total--;
               if (entry_total == 0)
                  head_slot = 0;
            end
         end
         OP_FLUSH: begin
            drops_seen    = drops_seen + entry_total;
            entry_total   = 0;
            head_slot     = 0;
            bytes_waiting = 0;
         end
         default: ;
      endcase
      r.front_valid   = (entry_total != 0);
      r.front_length  = (entry_total != 0) ? len_slots[head_slot[SLOT_W-1:0]] : '0;
      r.front_id      = (entry_total != 0) ? id_slots[head_slot[SLOT_W-1:0]] : '0;
      r.queued_bytes  = bytes_waiting[19:0];
      r.dropped_count = drops_seen;
      r.max_payload   = cap[15:0];
      predicted_replies.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                  $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // results are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_replies.size() == 0) begin
               $display("%0t: result with no request outstanding, got status %0d",
                        $time, rsp_tuser);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("assigned_id", want.assigned_id, rsp_tdata[31:0]);
               check_field("front_valid", 32'(want.front_valid), 32'(rsp_tdata[32]));
               check_field("front_length", 32'(want.front_length), 32'(rsp_tdata[48:33]));
               check_field("front_id", want.front_id, rsp_tdata[80:49]);
               check_field("queued_bytes", 32'(want.queued_bytes), 32'(rsp_tdata[100:81]));
               check_field("dropped_count", want.dropped_count, rsp_tdata[132:101]);
               check_field("max_payload", 32'(want.max_payload), 32'(rsp_tdata[148:133]));
               check_field("pad", 32'd0, 32'(rsp_tdata[151:149]));
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(op_type'(req_tuser), req_tdata);
            accepted_total++;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (issued_total == accepted_total) begin
         if (outbound_requests.size() != 0 &&
             !(idle_mode == 1 && $urandom_range(0, 99) < 48) &&
             !(idle_mode == 3 && $urandom_range(0, 99) < 33)) begin
            item = outbound_requests.pop_front();
            req_tdata  <= item.length;
            req_tuser  <= item.op;
            req_tvalid <= 1'b1;
            issued_total++;
         end else
            req_tvalid <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (rx_hold)
         rsp_tready <= 1'b0;
      else if (idle_mode == 2 && $urandom_range(0, 99) < 48)
         rsp_tready <= 1'b0;
      else if (idle_mode == 3 && $urandom_range(0, 99) < 33)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= 1'b1;
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      rx_hold = 1'b0;
      wait (hold_request);
      @(posedge clock);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      logic [31:0] rd_want;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      case (idx)
         REG_LINK: begin
            cfg_link = value[0];
            rd_want  = {31'd0, value[0]};
         end
         REG_KNOWN: begin
            cfg_known = value[0];
            rd_want   = {31'd0, value[0]};
         end
         REG_PEER: begin
            cfg_peer = value[15:0];
            rd_want  = {16'd0, value[15:0]};
         end
         REG_PATH: begin
            cfg_path = value[15:0];
            rd_want  = {16'd0, value[15:0]};
         end
         REG_CID: begin
            cfg_cid = value[4:0];
            rd_want = {27'd0, value[4:0]};
         end
         REG_BUDGET: begin
            cfg_budget = value[19:0];
            rd_want    = {12'd0, value[19:0]};
         end
         default: rd_want = '0;
      endcase
      // address still selects the register just written
      if (csr_pready !== 1'b1 || csr_prdata !== rd_want) begin
         $display("%0t: register %0d read back mismatch, expected 0x%0h, got 0x%0h",
                  $time, idx, rd_want, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_link(input link_cfg_type c);
      csr_write(REG_LINK, {31'd0, c.link});
      csr_write(REG_KNOWN, {31'd0, c.known});
      csr_write(REG_PEER, {16'd0, c.peer});
      csr_write(REG_PATH, {16'd0, c.path});
      csr_write(REG_CID, {27'd0, c.cid});
      csr_write(REG_BUDGET, {12'd0, c.budget});
   endtask

   task automatic add_request(input op_type op, input logic [15:0] len);
      request_type q;
      q.op     = op;
      q.length = len;
      outbound_requests.push_back(q);
   endtask

   task automatic wait_idle();
      while (outbound_requests.size() != 0 || issued_total != accepted_total ||
             predicted_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int          p;
      int          n;
      int          pick;
      int unsigned cap;
      logic [15:0] len;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OP_NOP;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      issued_total = 0;
      accepted_total = 0;
      fail_count   = 0;
      idle_mode    = 0;
      hold_request = 1'b0;

      cfg_link   = 1'b0;
      cfg_known  = 1'b0;
      cfg_peer   = '0;
      cfg_path   = PATH_RESET;
      cfg_cid    = '0;
      cfg_budget = BUDGET_RESET;
      head_slot  = 0;
      entry_total = 0;
      bytes_waiting = 0;
      next_datagram_id = '0;
      drops_seen = '0;
      len_slots  = '{default: '0};
      id_slots   = '{default: '0};

      phase_cfg[0]  = '{1'b1, 1'b1, 16'd1500,  16'd1500,  5'd0,  20'd65536};
      phase_cfg[1]  = '{1'b1, 1'b1, 16'd200,   16'd1200,  5'd20, 20'd3000};
      phase_cfg[2]  = '{1'b1, 1'b1, 16'd65535, 16'd65535, 5'd0,  20'd1048575};
      // budget drops below what the previous phase left waiting
      phase_cfg[3]  = '{1'b1, 1'b1, 16'd800,   16'd1400,  5'd20, 20'd1000};
      phase_cfg[4]  = '{1'b0, 1'b1, 16'd1200,  16'd1200,  5'd4,  20'd65536};
      phase_cfg[5]  = '{1'b1, 1'b0, 16'd1200,  16'd1200,  5'd4,  20'd65536};
      phase_cfg[6]  = '{1'b1, 1'b1, 16'd3,     16'd24,    5'd0,  20'd65536};
      phase_cfg[7]  = '{1'b1, 1'b1, 16'd0,     16'd0,     5'd0,  20'd65536};
      phase_cfg[8]  = '{1'b1, 1'b1, 16'd4,     16'd25,    5'd0,  20'd65536};
      phase_cfg[9]  = '{1'b1, 1'b1, 16'd1200,  16'd1200,  5'd5,  20'd0};
      phase_cfg[10] = '{1'b1, 1'b1, 16'd65535, 16'd65535, 5'd20, 20'd1048575};
      phase_cfg[11] = '{1'b1, 1'b1, 16'd600,   16'd900,   5'd10, 20'd4000};

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // link down after reset
      add_request(OP_SEND, 16'd100);
      add_request(OP_POP, 16'd0);
      add_request(OP_FLUSH, 16'd0);
      add_request(OP_NOP, 16'hFFFF);
      wait_idle();

      // limit 1168, budget 2000
      program_link('{1'b1, 1'b1, 16'd1200, 16'd1200, 5'd8, 20'd2000});
      add_request(OP_SEND, 16'd0);
      add_request(OP_SEND, 16'd1168);
      add_request(OP_SEND, 16'd1169);
      add_request(OP_SEND, 16'hFFFF);
      add_request(OP_SEND, 16'd832);
      add_request(OP_SEND, 16'd1);
      add_request(OP_POP, 16'd0);
      add_request(OP_POP, 16'd0);
      add_request(OP_POP, 16'd0);
      add_request(OP_POP, 16'd0);
      add_request(OP_SEND, 16'd5);
      add_request(OP_FLUSH, 16'd0);
      add_request(OP_FLUSH, 16'd0);
      add_request(OP_NOP, 16'd0);
      wait_idle();

      for (p = 0; p < PHASES; p++) begin
         program_link(phase_cfg[p[PHASE_W-1:0]]);
         idle_mode = p % 4;
         cap = payload_cap();
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (cap != 0 && $urandom_range(0, 99) < 70)
               len = 16'($urandom_range(0, cap));
            else if (cap != 0 && $urandom_range(0, 99) < 40)
               len = 16'(cap + $urandom_range(0, 1));
            else
               len = 16'($urandom);
            if (pick < 58)
               add_request(OP_SEND, len);
            else if (pick < 88)
               add_request(OP_POP, len);
            else if (pick < 93)
               add_request(OP_FLUSH, len);
            else if (pick < 97)
               add_request(OP_NOP, len);
            else
               add_request(OP_SEND, 16'($urandom));
         end
         if (p == 0)
            hold_request = 1'b1;
         wait_idle();
      end

      idle_mode = 0;
      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
